// ----- rtl/core/dupd_pkg.sv -----
// ----------------------------------------------------------------------------
// dupd_pkg
// Types, character constants and lookup functions shared by the data URL
// payload decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dupd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [4:0] HEX_NONE    = 5'd16;
    localparam logic [6:0] SEXTET_NONE = 7'd64;
    localparam logic [5:0] SEXTET_62   = 6'd62;
    localparam logic [5:0] SEXTET_63   = 6'd63;

    // result queue
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
    localparam int unsigned MAX_RES = 3;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HEX  = 3'b100
    } t_esc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       error;
    } t_result;

    // results of one request, slot 0 first
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     slot;
    } t_push;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] d_num;
        logic [7:0] d_lo;
        logic [7:0] d_up;
        logic [4:0] r;
        d_num = c - 8'd48;
        d_lo  = c - 8'd87;
        d_up  = c - 8'd55;
        case (c) inside
            [8'h30:8'h39]: r = {1'b0, d_num[3:0]};
            [8'h61:8'h66]: r = {1'b0, d_lo[3:0]};
            [8'h41:8'h46]: r = {1'b0, d_up[3:0]};
            default:       r = HEX_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d_up;
        logic [7:0] d_lo;
        logic [7:0] d_num;
        logic [6:0] r;
        d_up  = c - 8'd65;
        d_lo  = c - 8'd71;
        d_num = c + 8'd4;
        case (c) inside
            [8'h41:8'h5A]:     r = {1'b0, d_up[5:0]};
            [8'h61:8'h7A]:     r = {1'b0, d_lo[5:0]};
            [8'h30:8'h39]:     r = {1'b0, d_num[5:0]};
            CH_PLUS, CH_DASH:  r = {1'b0, SEXTET_62};
            CH_SLASH, CH_UNDER: r = {1'b0, SEXTET_63};
            default:           r = SEXTET_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[CH_TAB:CH_CR], CH_SPACE});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dupd_in_if.sv -----
// ----------------------------------------------------------------------------
// dupd_in_if
// Request channel of the decoder: one raw payload character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dupd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_payload;

    modport source (output valid, output in_byte, output end_of_payload, input ready);
    modport sink   (input valid, input in_byte, input end_of_payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dupd_out_if.sv -----
// ----------------------------------------------------------------------------
// dupd_out_if
// Result channel of the decoder: one decoded byte or end marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dupd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       error;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output error, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input error, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/data_url_payload_decoder.sv -----
// ----------------------------------------------------------------------------
// data_url_payload_decoder
// Percent / base64 decoder for data URL payloads with a four-entry result queue.
// ----------------------------------------------------------------------------
// Takes one payload character per cycle and decodes it in the same cycle into
// zero to three results, which go into a four-entry result queue that drives
// the output channel. The input is ready whenever at most one result is
// queued, so a stream in which each character yields at most one result runs
// at one character per clock while the output channel never stalls; a
// character yielding two or three results (a malformed escape, or the flush at
// end of payload) pauses the input until the queue drains back to one entry.
// Write the mode register only between payloads while the block is idle.
`default_nettype none

module data_url_payload_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dupd_in_if.sink     i_in,
    dupd_out_if.source  o_out,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata
);

    localparam int unsigned QW = dupd_pkg::QPTR_W;
    localparam int unsigned CW = dupd_pkg::QCNT_W;

    dupd_pkg::t_push    push;
    dupd_pkg::t_result  r_queue [dupd_pkg::QDEPTH];
    logic [QW-1:0]      r_wr_ptr;
    logic [QW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               accept;
    logic               pop;
    logic [1:0]         push_n;

    assign i_in.ready = (r_count <= CW'(dupd_pkg::QDEPTH - dupd_pkg::MAX_RES));
    assign accept     = i_in.valid & i_in.ready;
    assign pop        = o_out.valid & o_out.ready;
    assign push_n     = accept ? push.count : 2'd0;

    dupd_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_in_byte        (i_in.in_byte),
        .i_end_of_payload (i_in.end_of_payload),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_push           (push)
    );

    assign n_count = r_count + CW'(push_n) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QW'(push_n);
            r_rd_ptr <= r_rd_ptr + QW'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < dupd_pkg::MAX_RES; k++) begin
            if (2'(k) < push_n) begin
                r_queue[r_wr_ptr + QW'(k)] <= push.slot[k];
            end
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.out_byte   = r_queue[r_rd_ptr].out_byte;
    assign o_out.byte_valid = r_queue[r_rd_ptr].byte_valid;
    assign o_out.last       = r_queue[r_rd_ptr].last;
    assign o_out.error      = r_queue[r_rd_ptr].error;

`ifndef NO_ASSERTIONS
    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(dupd_pkg::QDEPTH))
        else $error("result queue overflow");

    // an error is only reported on the final result of a payload
    a_error_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.error |-> o_out.last)
        else $error("error flag on a non-final result");

    // an end marker without data only closes a payload
    a_marker_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.byte_valid |-> o_out.last)
        else $error("end marker without last");

    // an accepted request that yields results shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (push.count != 2'd0) |=> o_out.valid)
        else $error("accepted result not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dupd_step.sv -----
// ----------------------------------------------------------------------------
// dupd_step
// Decoder state and the per-character decode: percent escapes or base64,
// producing up to three results for each accepted character.
// ----------------------------------------------------------------------------
`default_nettype none

module dupd_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_end_of_payload,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_wdata,
    output dupd_pkg::t_push     o_push
);

    logic               r_mode;
    dupd_pkg::t_esc     r_phase;
    logic [7:0]         r_held;
    logic [11:0]        r_acc;
    logic [2:0]         r_cnt;
    logic               r_pad;
    logic               r_err;

    dupd_pkg::t_esc     n_phase;
    logic [7:0]         n_held;
    logic [11:0]        n_acc;
    logic [2:0]         n_cnt;
    logic               n_pad;
    logic               n_err;

    logic [4:0]         hex_c;
    logic [6:0]         sx_c;
    logic [3:0]         cnt6;
    logic [4:0]         hex_h;
    logic [11:0]        acc_sh;
    logic [1:0]         n;
    dupd_pkg::t_result [2:0] slot;

    always_comb begin
        hex_c   = dupd_pkg::hex_of(i_in_byte);
        hex_h   = dupd_pkg::hex_of(r_held);
        sx_c    = dupd_pkg::sextet_of(i_in_byte);
        cnt6    = {1'b0, r_cnt} + 4'd6;
        acc_sh  = '0;
        n       = 2'd0;
        slot    = '0;
        n_phase = r_phase;
        n_held  = r_held;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_pad   = r_pad;
        n_err   = r_err;

        if (!r_mode) begin
            case (r_phase)
                dupd_pkg::ESC_PCT: begin
                    if (hex_c != dupd_pkg::HEX_NONE) begin
                        n_held  = i_in_byte;
                        n_phase = dupd_pkg::ESC_HEX;
                    end else begin
                        slot[n] = '{dupd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0};
                        n       = n + 2'd1;
                        if (i_in_byte == dupd_pkg::CH_PERCENT) begin
                            n_phase = dupd_pkg::ESC_PCT;
                        end else begin
                            n_phase = dupd_pkg::ESC_IDLE;
                            slot[n] = '{i_in_byte, 1'b1, 1'b0, 1'b0};
                            n       = n + 2'd1;
                        end
                    end
                end
                dupd_pkg::ESC_HEX: begin
                    if (hex_c != dupd_pkg::HEX_NONE) begin
                        n_phase = dupd_pkg::ESC_IDLE;
                        slot[n] = '{{hex_h[3:0], hex_c[3:0]}, 1'b1, 1'b0, 1'b0};
                        n       = n + 2'd1;
                    end else begin
                        // malformed: percent, held digit, then the character afresh
                        slot[n] = '{dupd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0};
                        n       = n + 2'd1;
                        slot[n] = '{r_held, 1'b1, 1'b0, 1'b0};
                        n       = n + 2'd1;
                        if (i_in_byte == dupd_pkg::CH_PERCENT) begin
                            n_phase = dupd_pkg::ESC_PCT;
                        end else begin
                            n_phase = dupd_pkg::ESC_IDLE;
                            slot[n] = '{i_in_byte, 1'b1, 1'b0, 1'b0};
                            n       = n + 2'd1;
                        end
                    end
                end
                default: begin
                    if (i_in_byte == dupd_pkg::CH_PERCENT) begin
                        n_phase = dupd_pkg::ESC_PCT;
                    end else begin
                        n_phase = dupd_pkg::ESC_IDLE;
                        slot[n] = '{i_in_byte, 1'b1, 1'b0, 1'b0};
                        n       = n + 2'd1;
                    end
                end
            endcase
        end else if (!r_err && !r_pad && !dupd_pkg::is_space(i_in_byte)) begin
            if (i_in_byte == dupd_pkg::CH_EQUALS) begin
                n_pad = 1'b1;
            end else if (sx_c == dupd_pkg::SEXTET_NONE) begin
                n_err = 1'b1;
            end else begin
                n_acc = {r_acc[5:0], sx_c[5:0]};
                if (cnt6 >= 4'd8) begin
                    n_cnt   = cnt6[2:0];
                    acc_sh  = n_acc >> n_cnt;
                    slot[n] = '{acc_sh[7:0], 1'b1, 1'b0, 1'b0};
                    n       = n + 2'd1;
                end else begin
                    n_cnt = cnt6[2:0];
                end
            end
        end

        if (i_end_of_payload) begin
            if (!r_mode) begin
                if (n_phase == dupd_pkg::ESC_PCT) begin
                    slot[n] = '{dupd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0};
                    n       = n + 2'd1;
                end else if (n_phase == dupd_pkg::ESC_HEX) begin
                    slot[n] = '{dupd_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0};
                    n       = n + 2'd1;
                    slot[n] = '{n_held, 1'b1, 1'b0, 1'b0};
                    n       = n + 2'd1;
                end
            end
            // end-only marker when nothing else came out
            if (n == 2'd0) begin
                slot[n] = '{8'h00, 1'b0, 1'b0, 1'b0};
                n       = n + 2'd1;
            end
            slot[n - 2'd1].last  = 1'b1;
            slot[n - 2'd1].error = r_mode & n_err;
            n_phase = dupd_pkg::ESC_IDLE;
            n_held  = '0;
            n_acc   = '0;
            n_cnt   = '0;
            n_pad   = 1'b0;
            n_err   = 1'b0;
        end

        o_push.count = n;
        o_push.slot  = slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= dupd_pkg::ESC_IDLE;
            r_held  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_pad   <= n_pad;
                r_err   <= n_err;
            end
        end
    end

endmodule

`default_nettype wire
